// ===== rtl/elg_pkg.sv =====
// ----------------------------------------------------------------------------
// elg_pkg
// Shared widths, register codes, reset values and sequencer states of the
// ElGamal encrypt/decrypt block.
// ----------------------------------------------------------------------------
package elg_pkg;

  // Width of every wide field on the ports and of the configuration data.
  localparam int FIELD_W          = 31;
  localparam int BYTE_W           = 8;
  localparam int MODULUS_BITS_DEF = 31;
  localparam int CFG_IDX_W        = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_KEY = 2'd3;

  // Register values after reset.
  localparam logic [FIELD_W-1:0] MODULUS_RST     = 31'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] GENERATOR_RST   = 31'd7;
  localparam logic [FIELD_W-1:0] PUBLIC_KEY_RST  = 31'd1;
  localparam logic [FIELD_W-1:0] PRIVATE_KEY_RST = 31'd0;

  // Item mode.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEC_EXP,
    ST_POW_INIT,
    ST_SQR,
    ST_SQ_DONE,
    ST_ML_DONE,
    ST_POW_END,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/elg_in_if.sv =====
// ----------------------------------------------------------------------------
// elg_in_if
// Input channel of the ElGamal block: mode, message byte, nonce and the
// received key and cipher parts, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface elg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [elg_pkg::BYTE_W-1:0]  message_byte;
  logic [elg_pkg::FIELD_W-1:0] nonce;
  logic [elg_pkg::FIELD_W-1:0] key_part_in;
  logic [elg_pkg::FIELD_W-1:0] cipher_part_in;

  modport source (
    output valid, mode, message_byte, nonce, key_part_in, cipher_part_in,
    input  ready
  );
  modport sink (
    input  valid, mode, message_byte, nonce, key_part_in, cipher_part_in,
    output ready
  );
endinterface

// ===== rtl/elg_out_if.sv =====
// ----------------------------------------------------------------------------
// elg_out_if
// Result channel of the ElGamal block: key part, cipher part and the
// recovered value with its low byte, with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface elg_out_if;
  logic                        valid;
  logic                        ready;
  logic [elg_pkg::FIELD_W-1:0] key_part;
  logic [elg_pkg::FIELD_W-1:0] cipher_part;
  logic [elg_pkg::FIELD_W-1:0] plain_value;
  logic [elg_pkg::BYTE_W-1:0]  plain_byte;

  modport source (
    output valid, key_part, cipher_part, plain_value, plain_byte,
    input  ready
  );
  modport sink (
    input  valid, key_part, cipher_part, plain_value, plain_byte,
    output ready
  );
endinterface

// ===== rtl/elgamal_encrypt_decrypt.sv =====
// ----------------------------------------------------------------------------
// Each multiply runs on one bit-serial unit. A modulus below 2 skips the computation and gives zero
// results. Throughput: one item at a time; in_ready returns when the result is loaded. Synchronous
// reset (rst_n low) empties the output register, idles the sequencer and reloads the configuration
// registers.
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt
// Byte-wise ElGamal encryption and decryption over a configurable prime
// modulus, built around a shared shift-add modular multiplier.
// ----------------------------------------------------------------------------
module elgamal_encrypt_decrypt #(
  parameter int MODULUS_BITS = elg_pkg::MODULUS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  elg_in_if.sink                            in_ch,
  elg_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [elg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [elg_pkg::FIELD_W-1:0]       cfg_wdata
);

  localparam int W  = MODULUS_BITS;
  localparam int CW = $clog2(W + 1);
  localparam int FW = elg_pkg::FIELD_W;

  localparam logic [W-1:0]  ONE_W  = W'(1);
  localparam logic [CW-1:0] STEPS  = CW'(W);
  localparam logic [CW-1:0] CNT_1  = CW'(1);

  // Configuration registers.
  logic [FW-1:0] modulus_r, generator_r, public_key_r, private_key_r;

  // Sequencer.
  elg_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic            mode_r, mode_nxt;
  logic            second_r, second_nxt;
  logic [W-1:0]    opx_r, opx_nxt;
  logic [W-1:0]    opy_r, opy_nxt;
  logic [W-1:0]    exp_r, exp_nxt;
  logic [W-1:0]    base_r, base_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [CW-1:0]   ecnt_r, ecnt_nxt;

  // Shared multiply/reduce unit: mul_acc = mul_a * mul_b mod mul_m.
  logic [W-1:0]    mul_a_r, mul_a_nxt;
  logic [W-1:0]    mul_b_r, mul_b_nxt;
  logic [W-1:0]    mul_m_r, mul_m_nxt;
  logic [W-1:0]    mul_acc_r, mul_acc_nxt;
  logic [CW-1:0]   mul_cnt_r, mul_cnt_nxt;

  // Results and output register.
  logic [W-1:0]    kp_r, kp_nxt, cp_r, cp_nxt, pv_r, pv_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    out_kp_r, out_kp_nxt, out_cp_r, out_cp_nxt, out_pv_r, out_pv_nxt;

  logic [W-1:0]    p, pm1, mul_add, mul_red;
  logic            p_small;
  logic [W+1:0]    mul_t;
  logic [W+2:0]    mul_d1, mul_d2;

  assign p       = modulus_r[W-1:0];
  assign pm1     = p - ONE_W;
  assign p_small = (p[W-1:1] == '0);

  // One multiplier bit per cycle: acc = 2*acc + bit*a, then bring it back
  // below the modulus. Since acc and a stay below m, at most 2m is removed.
  assign mul_add = mul_b_r[W-1] ? mul_a_r : '0;
  assign mul_t   = {1'b0, mul_acc_r, 1'b0} + {2'b00, mul_add};
  assign mul_d1  = {1'b0, mul_t} - {3'b000, mul_m_r};
  assign mul_d2  = {1'b0, mul_t} - {2'b00, mul_m_r, 1'b0};
  assign mul_red = !mul_d2[W+2] ? mul_d2[W-1:0] :
                   !mul_d1[W+2] ? mul_d1[W-1:0] : mul_t[W-1:0];

  assign in_ch.ready        = rst_n && (state_r == elg_pkg::ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_part    = FW'(out_kp_r);
  assign out_ch.cipher_part = FW'(out_cp_r);
  assign out_ch.plain_value = FW'(out_pv_r);
  assign out_ch.plain_byte  = out_pv_r[elg_pkg::BYTE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mode_nxt      = mode_r;
    second_nxt    = second_r;
    opx_nxt       = opx_r;
    opy_nxt       = opy_r;
    exp_nxt       = exp_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    ecnt_nxt      = ecnt_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_m_nxt     = mul_m_r;
    mul_acc_nxt   = mul_acc_r;
    mul_cnt_nxt   = mul_cnt_r;
    kp_nxt        = kp_r;
    cp_nxt        = cp_r;
    pv_nxt        = pv_r;
    out_kp_nxt    = out_kp_r;
    out_cp_nxt    = out_cp_r;
    out_pv_nxt    = out_pv_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      elg_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt   = in_ch.mode;
          second_nxt = 1'b0;
          if (p_small) begin
            kp_nxt    = '0;
            cp_nxt    = '0;
            pv_nxt    = '0;
            state_nxt = elg_pkg::ST_DONE;
          end else if (in_ch.mode == elg_pkg::MODE_ENCRYPT) begin
            opx_nxt     = in_ch.nonce[W-1:0];
            opy_nxt     = W'(in_ch.message_byte);
            exp_nxt     = in_ch.nonce[W-1:0];
            // Reduce the generator modulo p.
            mul_a_nxt   = ONE_W;
            mul_b_nxt   = generator_r[W-1:0];
            mul_m_nxt   = p;
            mul_acc_nxt = '0;
            mul_cnt_nxt = STEPS;
            ret_nxt     = elg_pkg::ST_POW_INIT;
            state_nxt   = elg_pkg::ST_MUL;
          end else begin
            opx_nxt     = in_ch.key_part_in[W-1:0];
            opy_nxt     = in_ch.cipher_part_in[W-1:0];
            // Reduce the private key modulo p-1.
            mul_a_nxt   = ONE_W;
            mul_b_nxt   = private_key_r[W-1:0];
            mul_m_nxt   = pm1;
            mul_acc_nxt = '0;
            mul_cnt_nxt = STEPS;
            ret_nxt     = elg_pkg::ST_DEC_EXP;
            state_nxt   = elg_pkg::ST_MUL;
          end
        end
      end

      elg_pkg::ST_MUL: begin
        mul_acc_nxt = mul_red;
        mul_b_nxt   = mul_b_r << 1;
        mul_cnt_nxt = mul_cnt_r - CNT_1;
        if (mul_cnt_r == CNT_1) begin
          state_nxt = ret_r;
        end
      end

      elg_pkg::ST_DEC_EXP: begin
        exp_nxt     = pm1 - mul_acc_r;
        mul_a_nxt   = ONE_W;
        mul_b_nxt   = opx_r;
        mul_m_nxt   = p;
        mul_acc_nxt = '0;
        mul_cnt_nxt = STEPS;
        ret_nxt     = elg_pkg::ST_POW_INIT;
        state_nxt   = elg_pkg::ST_MUL;
      end

      elg_pkg::ST_POW_INIT: begin
        base_nxt  = mul_acc_r;
        acc_nxt   = ONE_W;
        ecnt_nxt  = STEPS;
        state_nxt = elg_pkg::ST_SQR;
      end

      elg_pkg::ST_SQR: begin
        if (ecnt_r == '0) begin
          state_nxt = elg_pkg::ST_POW_END;
        end else begin
          mul_a_nxt   = acc_r;
          mul_b_nxt   = acc_r;
          mul_m_nxt   = p;
          mul_acc_nxt = '0;
          mul_cnt_nxt = STEPS;
          ret_nxt     = elg_pkg::ST_SQ_DONE;
          state_nxt   = elg_pkg::ST_MUL;
        end
      end

      elg_pkg::ST_SQ_DONE: begin
        acc_nxt = mul_acc_r;
        if (exp_r[W-1]) begin
          mul_a_nxt   = base_r;
          mul_b_nxt   = mul_acc_r;
          mul_m_nxt   = p;
          mul_acc_nxt = '0;
          mul_cnt_nxt = STEPS;
          ret_nxt     = elg_pkg::ST_ML_DONE;
          state_nxt   = elg_pkg::ST_MUL;
        end else begin
          exp_nxt   = exp_r << 1;
          ecnt_nxt  = ecnt_r - CNT_1;
          state_nxt = elg_pkg::ST_SQR;
        end
      end

      elg_pkg::ST_ML_DONE: begin
        acc_nxt   = mul_acc_r;
        exp_nxt   = exp_r << 1;
        ecnt_nxt  = ecnt_r - CNT_1;
        state_nxt = elg_pkg::ST_SQR;
      end

      elg_pkg::ST_POW_END: begin
        mul_m_nxt   = p;
        mul_acc_nxt = '0;
        mul_cnt_nxt = STEPS;
        state_nxt   = elg_pkg::ST_MUL;
        if (mode_r == elg_pkg::MODE_ENCRYPT && !second_r) begin
          // The key part is done; now raise the public key to the nonce.
          kp_nxt     = acc_r;
          second_nxt = 1'b1;
          exp_nxt    = opx_r;
          mul_a_nxt  = ONE_W;
          mul_b_nxt  = public_key_r[W-1:0];
          ret_nxt    = elg_pkg::ST_POW_INIT;
        end else begin
          // Scanning the raw message or cipher value reduces it on the way.
          mul_a_nxt  = acc_r;
          mul_b_nxt  = opy_r;
          ret_nxt    = elg_pkg::ST_FINISH;
        end
      end

      elg_pkg::ST_FINISH: begin
        if (mode_r == elg_pkg::MODE_DECRYPT) begin
          kp_nxt = '0;
          cp_nxt = '0;
          pv_nxt = mul_acc_r;
        end else begin
          cp_nxt = mul_acc_r;
          pv_nxt = '0;
        end
        state_nxt = elg_pkg::ST_DONE;
      end

      elg_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kp_nxt    = kp_r;
          out_cp_nxt    = cp_r;
          out_pv_nxt    = pv_r;
          state_nxt     = elg_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = elg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= elg_pkg::ST_IDLE;
      ret_r       <= elg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r     <= elg_pkg::MODULUS_RST;
      generator_r   <= elg_pkg::GENERATOR_RST;
      public_key_r  <= elg_pkg::PUBLIC_KEY_RST;
      private_key_r <= elg_pkg::PRIVATE_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        elg_pkg::CFG_MODULUS:     modulus_r     <= cfg_wdata;
        elg_pkg::CFG_GENERATOR:   generator_r   <= cfg_wdata;
        elg_pkg::CFG_PUBLIC_KEY:  public_key_r  <= cfg_wdata;
        elg_pkg::CFG_PRIVATE_KEY: private_key_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    second_r  <= second_nxt;
    opx_r     <= opx_nxt;
    opy_r     <= opy_nxt;
    exp_r     <= exp_nxt;
    base_r    <= base_nxt;
    acc_r     <= acc_nxt;
    ecnt_r    <= ecnt_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    mul_m_r   <= mul_m_nxt;
    mul_acc_r <= mul_acc_nxt;
    mul_cnt_r <= mul_cnt_nxt;
    kp_r      <= kp_nxt;
    cp_r      <= cp_nxt;
    pv_r      <= pv_nxt;
    out_kp_r  <= out_kp_nxt;
    out_cp_r  <= out_cp_nxt;
    out_pv_r  <= out_pv_nxt;
  end

endmodule

// ===== rtl/elg_chk.sv =====
// ----------------------------------------------------------------------------
// elg_chk
// Port-level checks of the ElGamal block, bound to its top level.
// ----------------------------------------------------------------------------
module elg_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [elg_pkg::FIELD_W-1:0] plain_value,
  input logic [elg_pkg::BYTE_W-1:0]  plain_byte
);

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // The block works on one item at a time.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A new result appears exactly when the sequencer returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while still busy");

  // The byte output is always the low byte of the recovered value.
  a_byte_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> plain_byte == plain_value[elg_pkg::BYTE_W-1:0])
    else $error("plain byte does not match plain value");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind elgamal_encrypt_decrypt elg_chk u_elg_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .plain_value (out_ch.plain_value),
  .plain_byte  (out_ch.plain_byte)
);
